>>> hw/rtl/orps_pkg.sv
// shared types, constants and tables for the reference point selector
// no dependencies

package orps_pkg;

    // default fraction bits of the cordic cos/sin words
    localparam int TRIG_FRAC_BITS_DEF = 15;

    // cordic gain in q30 and number of rotation steps
    localparam longint GAIN_Q30 = 64'd652032874;
    localparam int CORDIC_STEPS = 14;

    // configuration register indexes
    localparam logic [0:0] CFG_REAR_BUMPER_OFFSET = 1'd0;
    localparam logic [0:0] CFG_DEFAULT_REF_LAT_THRESHOLD = 1'd1;

    // configuration reset values
    localparam logic signed [13:0] REAR_BUMPER_OFFSET_RST = 14'sd0;
    localparam logic [14:0] DEFAULT_REF_LAT_THRESHOLD_RST = 15'd512;

    // zero-based point indexes forced by the default override
    localparam logic [2:0] IDX_FRONT_RIGHT = 3'd0;
    localparam logic [2:0] IDX_FRONT_LEFT = 3'd2;

    typedef enum logic [1:0] {
        SIDE_UNDEF = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2
    } side_t;

    // obstacle fields that travel with the cos/sin words
    typedef struct packed {
        logic signed [15:0] lon;
        logic signed [15:0] lat;
        logic [12:0]        len;
        logic [12:0]        wid;
        logic               front;
        side_t              side;
    } track_t;

    // arctangent table in 1/65536 turn
    function automatic logic signed [17:0] atan_turn(input logic [3:0] i);
        logic signed [17:0] r;
        begin
            case (i)
                4'd0:    r = 18'sd8192;
                4'd1:    r = 18'sd4836;
                4'd2:    r = 18'sd2555;
                4'd3:    r = 18'sd1297;
                4'd4:    r = 18'sd651;
                4'd5:    r = 18'sd326;
                4'd6:    r = 18'sd163;
                4'd7:    r = 18'sd81;
                4'd8:    r = 18'sd41;
                4'd9:    r = 18'sd20;
                4'd10:   r = 18'sd10;
                4'd11:   r = 18'sd5;
                4'd12:   r = 18'sd3;
                4'd13:   r = 18'sd1;
                default: r = 18'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> hw/rtl/orps_front.sv
// front part: accepts obstacles, classifies the approach side, runs the cordic
// depends on orps_pkg

module orps_front
    import orps_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
    localparam int CW = TRIG_FRAC_BITS + 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [15:0]   long_pos,
    input  logic signed [15:0]   lat_pos,
    input  logic signed [15:0]   heading_angle,
    input  logic signed [15:0]   lat_speed,
    input  logic [12:0]          box_length,
    input  logic [12:0]          box_width,
    input  logic                 is_front,
    input  logic                 q_full,
    output logic                 q_push,
    output track_t               q_track,
    output logic signed [CW-1:0] q_cos,
    output logic signed [CW-1:0] q_sin
);

    localparam longint X0_L =
        (GAIN_Q30 + (longint'(1) << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    localparam logic signed [CW-1:0] X0 = CW'(X0_L);

    logic                 busy_reg;
    logic [1:0]           cnt_reg;
    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [17:0]   z_reg, z_next;
    logic                 flip_reg;
    track_t               track_reg;

    logic                 last;
    logic                 accept;
    logic [15:0]          fold;
    logic [15:0]          ang;
    logic                 flip_in;
    side_t                side_in;

    assign last     = (cnt_reg == 2'd3);
    assign q_push   = busy_reg && last && !q_full;
    assign in_stall = busy_reg && !q_push;
    assign accept   = in_valid && !in_stall;

    // approach side and folded heading
    always_comb
    begin
        side_in = SIDE_UNDEF;
        if (heading_angle[15])
        begin
            if (lat_pos > 16'sd0 && lat_speed < 16'sd0)
                side_in = SIDE_LEFT;
        end
        else
        begin
            if (lat_pos < 16'sd0 && lat_speed > 16'sd0)
                side_in = SIDE_RIGHT;
        end
        fold = heading_angle[15] ? 16'(-heading_angle) : heading_angle;
        if (lat_speed[15])
            fold = 16'(-fold);
        flip_in = (fold >= 16'd16384) && (fold < 16'd49152);
        ang     = flip_in ? 16'(fold - 16'd32768) : fold;
    end

    // up to four cordic steps per cycle
    always_comb
    begin
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [17:0]   zs;
        logic [3:0]           i;
        xs = x_reg;
        ys = y_reg;
        zs = z_reg;
        for (int k = 0; k < 4; k++)
        begin
            i = {cnt_reg, 2'b00} + 4'(k);
            if (i < 4'(CORDIC_STEPS))
            begin
                if (!zs[17])
                begin
                    x_next = xs - (ys >>> i);
                    ys     = ys + (xs >>> i);
                    zs     = zs - atan_turn(i);
                end
                else
                begin
                    x_next = xs + (ys >>> i);
                    ys     = ys - (xs >>> i);
                    zs     = zs + atan_turn(i);
                end
                xs = x_next;
            end
        end
        x_next = xs;
        y_next = ys;
        z_next = zs;
    end

    assign q_cos   = flip_reg ? CW'(-x_next) : x_next;
    assign q_sin   = flip_reg ? CW'(-y_next) : y_next;
    assign q_track = track_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 2'd0;
        end
        else if (busy_reg && !last)
        begin
            cnt_reg <= cnt_reg + 2'd1;
        end
        else if (q_push)
        begin
            busy_reg <= 1'b0;
        end
    end

    // rotation state and payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg     <= X0;
            y_reg     <= '0;
            z_reg     <= 18'(signed'(ang));
            flip_reg  <= flip_in;
            track_reg <= '{lon: long_pos, lat: lat_pos, len: box_length,
                           wid: box_width, front: is_front, side: side_in};
        end
        else if (busy_reg && !last)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule

>>> hw/rtl/orps_queue.sv
// two-entry queue between the front and back parts
// no dependencies

module orps_queue #(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output logic [W-1:0] dout
);

    logic [W-1:0] mem_reg [0:1];
    logic         wr_reg;
    logic         rd_reg;
    logic [1:0]   cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign dout  = mem_reg[rd_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= din;
    end

endmodule

>>> hw/rtl/orps_back.sv
// back part: box points, distance search, default override, output word
// depends on orps_pkg

module orps_back
    import orps_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
    localparam int CW = TRIG_FRAC_BITS + 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  track_t               q_track,
    input  logic signed [CW-1:0] q_cos,
    input  logic signed [CW-1:0] q_sin,
    input  logic signed [13:0]   rear_bumper_offset,
    input  logic [14:0]          default_ref_lat_threshold,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [16:0]   ref_x,
    output logic signed [16:0]   ref_y,
    output logic [3:0]           ref_index,
    output logic [1:0]           approach_side
);

    localparam int PW = CW + 14;
    localparam int OW = PW + 2;
    localparam int SW = TRIG_FRAC_BITS + 20;
    localparam int FS = TRIG_FRAC_BITS + 2;

    typedef struct packed {
        logic        found;
        logic [36:0] d2;
        logic [2:0]  idx;
    } cand_t;

    // lower index in a keeps ties
    function automatic cand_t merge(input cand_t a, input cand_t b);
        cand_t r;
        begin
            if (!b.found)
                r = a;
            else if (!a.found || (b.d2 < a.d2))
                r = b;
            else
                r = a;
            return r;
        end
    endfunction

    logic                  en;
    logic [8:1]            v_reg;
    logic                  front_reg [1:7];
    side_t                 side_reg [1:7];
    logic signed [15:0]    lon1_reg;
    logic signed [15:0]    lat_reg [1:2];
    logic signed [PW-1:0]  a_reg, b_reg, c_reg, d_reg;
    logic signed [16:0]    px_reg [2:7][0:7];
    logic signed [16:0]    py_reg [2:7][0:7];
    logic signed [17:0]    dx_reg [0:7];
    logic                  skip3_reg [0:7];
    logic                  skip4_reg [0:7];
    logic signed [35:0]    sqx_reg [0:7];
    logic signed [33:0]    sqy_reg [0:7];
    cand_t                 c5_reg [0:3];
    cand_t                 c6_reg [0:1];
    cand_t                 c7_reg;
    logic signed [16:0]    ref_x_reg, ref_y_reg;
    logic [3:0]            ref_index_reg;
    side_t                 side8_reg;

    logic signed [16:0]    px_c [0:7];
    logic signed [16:0]    py_c [0:7];
    cand_t                 c5_c [0:3];
    logic [2:0]            idx_c;

    // whole pipe advances when the output word is free or taken
    assign en    = !v_reg[8] || !out_stall;
    assign q_pop = en && q_valid;

    // corner offsets and rounded points
    always_comb
    begin
        logic signed [OW-1:0] ox [0:3];
        logic signed [OW-1:0] oy [0:3];
        logic signed [SW-1:0] bx, by, vx, vy;
        logic signed [SW-1:0] half;
        int                   n;
        ox[0] = OW'(a_reg) + OW'(b_reg);
        ox[1] = OW'(a_reg) - OW'(b_reg);
        ox[2] = -ox[0];
        ox[3] = -ox[1];
        oy[0] = OW'(c_reg) - OW'(d_reg);
        oy[1] = OW'(c_reg) + OW'(d_reg);
        oy[2] = -oy[0];
        oy[3] = -oy[1];
        half  = SW'(1) <<< (FS - 1);
        bx    = (SW'(lon1_reg) <<< FS) + half;
        by    = (SW'(lat_reg[1]) <<< FS) + half;
        for (int i = 0; i < 4; i++)
        begin
            n  = (i + 1) % 4;
            vx = bx + (SW'(ox[i]) <<< 1);
            vy = by + (SW'(oy[i]) <<< 1);
            px_c[2*i] = vx[FS+16 -: 17];
            py_c[2*i] = vy[FS+16 -: 17];
            vx = bx + SW'(ox[i]) + SW'(ox[n]);
            vy = by + SW'(oy[i]) + SW'(oy[n]);
            px_c[2*i+1] = vx[FS+16 -: 17];
            py_c[2*i+1] = vy[FS+16 -: 17];
        end
    end

    // first level of the nearest-point search
    always_comb
    begin
        cand_t e0, e1;
        for (int j = 0; j < 4; j++)
        begin
            e0.found = !skip4_reg[2*j];
            e0.d2    = 37'(sqx_reg[2*j]) + 37'(sqy_reg[2*j]);
            e0.idx   = 3'(2*j);
            e1.found = !skip4_reg[2*j+1];
            e1.d2    = 37'(sqx_reg[2*j+1]) + 37'(sqy_reg[2*j+1]);
            e1.idx   = 3'(2*j+1);
            c5_c[j]  = merge(e0, e1);
        end
    end

    // default corner override
    always_comb
    begin
        logic signed [16:0] yc;
        logic [16:0]        my;
        logic               to_left, to_right;
        yc       = py_reg[7][c7_reg.idx];
        my       = yc[16] ? 17'(-yc) : 17'(yc);
        to_left  = (!front_reg[7] && side_reg[7] == SIDE_LEFT)
                || (front_reg[7] && side_reg[7] == SIDE_RIGHT);
        to_right = (!front_reg[7] && side_reg[7] == SIDE_RIGHT)
                || (front_reg[7] && side_reg[7] == SIDE_LEFT);
        idx_c    = c7_reg.idx;
        if (my >= {2'b00, default_ref_lat_threshold})
        begin
            if (to_left)
                idx_c = IDX_FRONT_LEFT;
            else if (to_right)
                idx_c = IDX_FRONT_RIGHT;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[7:1], q_valid};
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: rotation products
            a_reg       <= PW'(q_cos * signed'({1'b0, q_track.len}));
            b_reg       <= PW'(q_sin * signed'({1'b0, q_track.wid}));
            c_reg       <= PW'(q_sin * signed'({1'b0, q_track.len}));
            d_reg       <= PW'(q_cos * signed'({1'b0, q_track.wid}));
            lon1_reg    <= q_track.lon;
            lat_reg[1]  <= q_track.lat;
            front_reg[1] <= q_track.front;
            side_reg[1]  <= q_track.side;
            for (int s = 2; s <= 7; s++)
            begin
                front_reg[s] <= front_reg[s-1];
                side_reg[s]  <= side_reg[s-1];
            end
            lat_reg[2] <= lat_reg[1];
            // stage 2: points
            for (int i = 0; i < 8; i++)
            begin
                px_reg[2][i] <= px_c[i];
                py_reg[2][i] <= py_c[i];
            end
            for (int s = 3; s <= 7; s++)
            begin
                px_reg[s] <= px_reg[s-1];
                py_reg[s] <= py_reg[s-1];
            end
            // stage 3: offset x and lateral skip test
            for (int i = 0; i < 8; i++)
            begin
                dx_reg[i]    <= 18'(px_reg[2][i]) - 18'(rear_bumper_offset);
                skip3_reg[i] <= (py_reg[2][i][16] ? 17'(-py_reg[2][i]) : 17'(py_reg[2][i]))
                    > (lat_reg[2][15] ? 17'(-17'(lat_reg[2])) : 17'(lat_reg[2]));
            end
            // stage 4: squares
            for (int i = 0; i < 8; i++)
            begin
                sqx_reg[i]   <= 36'(dx_reg[i] * dx_reg[i]);
                sqy_reg[i]   <= 34'(py_reg[3][i] * py_reg[3][i]);
                skip4_reg[i] <= skip3_reg[i];
            end
            // stages 5 to 7: search tree
            c5_reg    <= c5_c;
            c6_reg[0] <= merge(c5_reg[0], c5_reg[1]);
            c6_reg[1] <= merge(c5_reg[2], c5_reg[3]);
            c7_reg    <= merge(c6_reg[0], c6_reg[1]);
            // stage 8: output word
            ref_x_reg     <= px_reg[7][idx_c];
            ref_y_reg     <= py_reg[7][idx_c];
            ref_index_reg <= {1'b0, idx_c} + 4'd1;
            side8_reg     <= side_reg[7];
        end
    end

    assign out_valid     = v_reg[8];
    assign ref_x         = ref_x_reg;
    assign ref_y         = ref_y_reg;
    assign ref_index     = ref_index_reg;
    assign approach_side = side8_reg;

    // no item is popped from the queue while the output word is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[8] && out_stall) |-> !q_pop)
        else $error("back pipe advanced under a stalled output");

    // index stays one-based within the eight points
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ref_index >= 4'd1 && ref_index <= 4'd8))
        else $error("reference index out of range");

    // the approach side is always one of the three defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (approach_side != 2'd3))
        else $error("approach side code invalid");

endmodule

>>> hw/rtl/obstacle_reference_point_select.sv
// top level of the obstacle reference point selector
// depends on orps_pkg, orps_front, orps_queue, orps_back
// path from accept to result valid: the cordic in the front part, then the queue, then the back pipe
// the cordic unit works on one word at a time at up to 4 of its 14 steps a cycle and waits while the queue is full
// the queue lets the front keep working while a result waits, until the queue is full
// reset: asynchronous, clears control and loads register reset values; no clearing pass

module obstacle_reference_point_select
    import orps_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [14:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  long_pos,
    input  logic signed [15:0]  lat_pos,
    input  logic signed [15:0]  heading_angle,
    input  logic signed [15:0]  lat_speed,
    input  logic [12:0]         box_length,
    input  logic [12:0]         box_width,
    input  logic                is_front,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [16:0]  ref_x,
    output logic signed [16:0]  ref_y,
    output logic [3:0]          ref_index,
    output logic [1:0]          approach_side
);

    localparam int CW = TRIG_FRAC_BITS + 3;
    localparam int QW = $bits(track_t) + 2 * CW;

    logic signed [13:0]   rbo_reg;
    logic [14:0]          thr_reg;

    logic                 q_push, q_full, q_pop, q_valid;
    track_t               f_track, b_track;
    logic signed [CW-1:0] f_cos, f_sin, b_cos, b_sin;
    logic [QW-1:0]        q_dout;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rbo_reg <= REAR_BUMPER_OFFSET_RST;
            thr_reg <= DEFAULT_REF_LAT_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REAR_BUMPER_OFFSET:        rbo_reg <= cfg_wdata[13:0];
                CFG_DEFAULT_REF_LAT_THRESHOLD: thr_reg <= cfg_wdata;
                default:                       ;
            endcase
        end
    end

    orps_front #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .long_pos      (long_pos),
        .lat_pos       (lat_pos),
        .heading_angle (heading_angle),
        .lat_speed     (lat_speed),
        .box_length    (box_length),
        .box_width     (box_width),
        .is_front      (is_front),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_track       (f_track),
        .q_cos         (f_cos),
        .q_sin         (f_sin)
    );

    orps_queue #(
        .W (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   ({f_track, f_cos, f_sin}),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (q_dout)
    );

    assign {b_track, b_cos, b_sin} = q_dout;

    orps_back #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_back (
        .clk                       (clk),
        .rst_n                     (rst_n),
        .q_valid                   (q_valid),
        .q_pop                     (q_pop),
        .q_track                   (b_track),
        .q_cos                     (b_cos),
        .q_sin                     (b_sin),
        .rear_bumper_offset        (rbo_reg),
        .default_ref_lat_threshold (thr_reg),
        .out_valid                 (out_valid),
        .out_stall                 (out_stall),
        .ref_x                     (ref_x),
        .ref_y                     (ref_y),
        .ref_index                 (ref_index),
        .approach_side             (approach_side)
    );

endmodule
